// ===== src/pfvp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the PCM FIFO to PWM duty block.
package pfvp_pkg;

    // Ring buffer geometry
    localparam int BUF_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int FILL_FW   = 10;
    localparam int CNT_W     = (ADDR_W + 1 > FILL_FW) ? ADDR_W + 1 : FILL_FW;

    // Audio constants
    localparam logic [7:0] SILENCE  = 8'd128;
    localparam logic [9:0] DUTY_MID = 10'd127;
    localparam logic [9:0] DUTY_MAX = 10'd255;

    // Action codes
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_VOLUME  = 2'd0;
    localparam logic [1:0] REG_MASTER  = 2'd1;
    localparam logic [1:0] REG_PLAYING = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] sample_in;
    } in_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] duty;
        logic       underrun;
        logic [9:0] fill_count;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;
        logic load_smp;
        logic do_gain;
        logic do_gdiv;
        logic do_scale;
        logic do_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_now;
    } dp_stat_t;

    // Gain curve lookup
    function automatic logic [7:0] gain_curve(input logic [3:0] lvl);
        logic [7:0] g;
        unique case (lvl)
            4'd0:    g = 8'd0;
            4'd1:    g = 8'd1;
            4'd2:    g = 8'd2;
            4'd3:    g = 8'd3;
            4'd4:    g = 8'd4;
            4'd5:    g = 8'd6;
            4'd6:    g = 8'd8;
            4'd7:    g = 8'd11;
            4'd8:    g = 8'd15;
            4'd9:    g = 8'd21;
            4'd10:   g = 8'd30;
            4'd11:   g = 8'd43;
            4'd12:   g = 8'd62;
            4'd13:   g = 8'd91;
            4'd14:   g = 8'd137;
            default: g = 8'd255;
        endcase
        return g;
    endfunction

    // Floor of x / 255 for any 16-bit x, by reciprocal with correction
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] t;
        y = {1'b0, x} + 17'd1;
        t = y + {8'd0, y[16:8]};
        return t[16:8];
    endfunction

    // Advance a ring index with wrap
    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] n;
        if (idx == ADDR_W'(BUF_DEPTH - 1))
            n = '0;
        else
            n = idx + ADDR_W'(1);
        return n;
    endfunction

endpackage

// ===== src/pfvp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pfvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pfvp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: ring buffer indices, sample store, config registers and duty arithmetic.
module pfvp_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfvp_pkg::in_t        in_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_data,
    input  pfvp_pkg::ctrl_cmd_t  cmd,
    output pfvp_pkg::dp_stat_t   stat,
    output pfvp_pkg::out_t       out_data
);

    localparam int AW = pfvp_pkg::ADDR_W;
    localparam int CW = pfvp_pkg::CNT_W;

    logic [AW-1:0]  rd_reg, rd_next;
    logic [AW-1:0]  wr_reg, wr_next;
    logic [7:0]     cur_reg, cur_next;
    logic           acc_reg, und_reg;
    logic [3:0]     vol_reg, mst_reg;
    logic           play_reg;
    logic [15:0]    prod_reg;
    logic [7:0]     gain_reg;
    logic           neg_reg;
    logic [22:0]    mag_reg;
    pfvp_pkg::out_t out_reg;

    logic [AW-1:0]  wr_nx;
    logic           push_ok, pop_now, underrun_now, clear_now;
    logic [7:0]     ram_rdata;
    logic [8:0]     gain_q;
    logic           neg;
    logic [7:0]     absc;
    logic [14:0]    m127;
    logic [8:0]     q;
    logic [9:0]     duty_s;
    logic [7:0]     duty;
    logic [CW-1:0]  fill;

    // Decode the accepted action
    assign wr_nx        = pfvp_pkg::ring_next(wr_reg);
    assign push_ok      = cmd.take && (in_data.action == pfvp_pkg::ACT_PUSH) && play_reg
                          && (wr_nx != rd_reg);
    assign pop_now      = cmd.take && (in_data.action == pfvp_pkg::ACT_TICK) && play_reg
                          && (rd_reg != wr_reg);
    assign underrun_now = cmd.take && (in_data.action == pfvp_pkg::ACT_TICK) && play_reg
                          && (rd_reg == wr_reg);
    assign clear_now    = cmd.take && (in_data.action == pfvp_pkg::ACT_CLEAR);

    assign stat.pop_now = pop_now;

    // Sample store
    pfvp_ram #(
        .WIDTH (8),
        .DEPTH (pfvp_pkg::BUF_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wr_reg),
        .wdata (in_data.sample_in),
        .re    (pop_now),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    // Next index and current sample values
    always_comb
    begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        cur_next = cur_reg;
        if (push_ok)
            wr_next = wr_nx;
        if (pop_now)
            rd_next = pfvp_pkg::ring_next(rd_reg);
        if (underrun_now)
            cur_next = pfvp_pkg::SILENCE;
        if (clear_now)
        begin
            rd_next  = '0;
            wr_next  = '0;
            cur_next = pfvp_pkg::SILENCE;
        end
        if (cmd.load_smp)
            cur_next = ram_rdata;
    end

    // Hold ring state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            cur_reg  <= pfvp_pkg::SILENCE;
            vol_reg  <= 4'd15;
            mst_reg  <= 4'd15;
            play_reg <= 1'b0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cur_reg <= cur_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pfvp_pkg::REG_VOLUME:  vol_reg  <= cfg_data;
                    pfvp_pkg::REG_MASTER:  mst_reg  <= cfg_data;
                    pfvp_pkg::REG_PLAYING: play_reg <= cfg_data[0];
                    default:               ;
                endcase
            end
        end
    end

    // Divide the gain product by 255, rounded to nearest, to one combined gain
    assign gain_q = pfvp_pkg::div255(prod_reg + 16'd127);

    // Centered sample magnitude times 127
    assign neg  = (cur_reg < pfvp_pkg::SILENCE);
    assign absc = neg ? (pfvp_pkg::SILENCE - cur_reg) : (cur_reg - pfvp_pkg::SILENCE);
    assign m127 = {absc, 7'd0} - {7'd0, absc};

    // Scale down by 32640 as a shift by 7 and a division by 255
    assign q = pfvp_pkg::div255(mag_reg[22:7]);

    // Apply sign around mid scale and clamp
    always_comb
    begin
        if (neg_reg)
            duty_s = pfvp_pkg::DUTY_MID - {1'b0, q};
        else
            duty_s = pfvp_pkg::DUTY_MID + {1'b0, q};
        if (duty_s[9])
            duty = 8'd0;
        else if (duty_s > pfvp_pkg::DUTY_MAX)
            duty = 8'd255;
        else
            duty = duty_s[7:0];
    end

    // Fill level from the indices
    always_comb
    begin
        if (wr_reg >= rd_reg)
            fill = CW'(wr_reg) - CW'(rd_reg);
        else
            fill = CW'(pfvp_pkg::BUF_DEPTH) - CW'(rd_reg) + CW'(wr_reg);
    end

    // Flags, gain and scale pipeline, result register
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            acc_reg <= push_ok;
            und_reg <= underrun_now;
        end
        if (cmd.do_gain)
            prod_reg <= pfvp_pkg::gain_curve(vol_reg) * pfvp_pkg::gain_curve(mst_reg);
        if (cmd.do_gdiv)
            gain_reg <= gain_q[7:0];
        if (cmd.do_scale)
        begin
            mag_reg <= m127 * gain_reg;
            neg_reg <= neg;
        end
        if (cmd.do_out)
        begin
            out_reg.accepted   <= acc_reg;
            out_reg.duty       <= duty;
            out_reg.underrun   <= und_reg;
            out_reg.fill_count <= fill[pfvp_pkg::FILL_FW-1:0];
        end
    end

    assign out_data = out_reg;

endmodule

// ===== src/pfvp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one item through load, gain, scale and output steps.
module pfvp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    input  pfvp_pkg::dp_stat_t   stat,
    output pfvp_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_GAIN  = 3'd2;
    localparam logic [2:0] S_GDIV  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DUTY  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !(out_valid_reg && out_stall);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                    state_next = stat.pop_now ? S_LOAD : S_GAIN;
            end
            S_LOAD:
            begin
                cmd.load_smp = 1'b1;
                state_next   = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.do_gain = 1'b1;
                state_next  = S_GDIV;
            end
            S_GDIV:
            begin
                cmd.do_gdiv = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.do_scale = 1'b1;
                state_next   = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.do_out = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.do_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/pcm_fifo_volume_pwm_duty.sv =====
`timescale 1ns / 1ps
// Top level: PCM sample FIFO with two-stage volume feeding a PWM duty value.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data   (action, sample_in)
//   out       output     out_valid/out_stall out_data  (accepted, duty, underrun, fill_count)
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// An item passes through the controller sequence: accept, sample read from
// the store (only for a tick that pops a sample), gain product, gain divide,
// scale multiply, duty and result load.
// Reset clears indices, sets the current sample to silence and volumes to 15.
// The store has no clearing pass; entries are read only after being written.
// A result waits in the output register while the next item is taken; a
// finished item holds in the last step only while that register is still stalled.
module pcm_fifo_volume_pwm_duty (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pfvp_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output pfvp_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [3:0]      cfg_data
);

    pfvp_pkg::ctrl_cmd_t cmd;
    pfvp_pkg::dp_stat_t  stat;

    // Sequencer
    pfvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Buffer and arithmetic
    pfvp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // An accepted item keeps the input stalled on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transfer");

    // A new result appears only at the end of an item's sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a preceding item");

    // A push result never also reports underrun
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.accepted && out_data.underrun))
        else $error("accepted and underrun both set");

endmodule
